// ----- rtl/lbzi_pkg.sv -----
// shared constants for the lorentz boost and interval pipeline
// no dependencies
`timescale 1ns / 1ps

package lbzi_pkg;

  localparam int COMP_WIDTH_DEF = 24;          // component width, Q(W-16).16
  localparam int VEL_W          = 16;          // velocity width, Q1.15
  localparam int VEL_FRAC       = 15;          // velocity fraction bits
  localparam int DSQ_W          = 31;          // 1 - v^2 in Q1.30
  localparam int ROOT_W         = 32;          // sqrt(1 - v^2) in Q1.31
  localparam int RAD_W          = 2 * ROOT_W;  // radicand of the gamma root
  localparam int GAMMA_W        = 31;          // gamma in Q9.22
  localparam int GAMMA_FRAC     = 22;
  localparam int GAMMA_EXP      = 53;          // gamma = 2^53 / root

  localparam logic signed [VEL_W-1:0] VEL_MIN   = {1'b1, {(VEL_W-1){1'b0}}};
  localparam logic signed [VEL_W-1:0] VEL_CLAMP = {1'b1, {(VEL_W-2){1'b0}}, 1'b1};

endpackage

// ----- rtl/lbzi_if.sv -----
// valid/ready channel interfaces for input vectors and boosted results
// depends on lbzi_pkg
`timescale 1ns / 1ps

interface lbzi_in_if #(
  parameter int COMP_WIDTH = lbzi_pkg::COMP_WIDTH_DEF
);
  logic                                 valid;
  logic                                 ready;
  logic signed [COMP_WIDTH-1:0]         time_in;
  logic signed [COMP_WIDTH-1:0]         xpos_in;
  logic signed [COMP_WIDTH-1:0]         ypos_in;
  logic signed [COMP_WIDTH-1:0]         zpos_in;
  logic signed [lbzi_pkg::VEL_W-1:0]    velocity;

  modport source (output valid, time_in, xpos_in, ypos_in, zpos_in, velocity, input ready);
  modport sink   (input valid, time_in, xpos_in, ypos_in, zpos_in, velocity, output ready);
endinterface

interface lbzi_out_if #(
  parameter int COMP_WIDTH = lbzi_pkg::COMP_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COMP_WIDTH-1:0] time_out;
  logic signed [COMP_WIDTH-1:0] xpos_out;
  logic signed [COMP_WIDTH-1:0] ypos_out;
  logic signed [COMP_WIDTH-1:0] zpos_out;
  logic        [COMP_WIDTH-1:0] interval;
  logic                         saturated;

  modport source (output valid, time_out, xpos_out, ypos_out, zpos_out, interval, saturated,
                  input ready);
  modport sink   (input valid, time_out, xpos_out, ypos_out, zpos_out, interval, saturated,
                  output ready);
endinterface

// ----- rtl/lorentz_boost_z_and_interval.sv -----
// top level: lorentz boost along z plus spacetime interval, fully pipelined
// depends on lbzi_pkg, lbzi_if, lbzi_delay, lbzi_sqrt_pipe, lbzi_div_pipe
`timescale 1ns / 1ps

// Takes one four-vector and velocity per cycle and returns one result per
// cycle, in order, with a latency that does not depend on COMP_WIDTH. The
// latency is set by the gamma path: a 32-stage square root of 1 - v^2, a
// 31-stage divider forming gamma, then one multiply stage and one round and
// saturate stage, behind two input stages. The interval root (COMP_WIDTH
// stages) runs in parallel and is delayed to meet it. The whole pipeline
// advances together; when the output holds an untaken result the pipeline
// freezes and vec.ready drops, otherwise a transaction may enter every cycle.

module lorentz_boost_z_and_interval #(
  parameter int COMP_WIDTH = lbzi_pkg::COMP_WIDTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  lbzi_in_if.sink        vec,
  lbzi_out_if.source     res
);
  import lbzi_pkg::*;

  localparam int W    = COMP_WIDTH;
  localparam int PW   = W + VEL_FRAC + 2;      // z*2^15 - v*t + 2^14
  localparam int DW   = PW - VEL_FRAC;         // rounded difference, Q.16
  localparam int PRW  = DW + GAMMA_W + 1;      // gamma * difference
  localparam int RW   = PRW - GAMMA_FRAC;      // after the gamma rounding
  localparam int SQW  = 2 * W;                 // squares and interval magnitude

  // stage timeline
  localparam int T_ROOT = 2 + ROOT_W;          // gamma root ready
  localparam int T_GAM  = T_ROOT + GAMMA_W;    // gamma ready
  localparam int T_PROD = T_GAM + 1;           // products registered
  localparam int LAT    = T_PROD + 1;          // output register
  localparam int D_DIFF = T_GAM - 2;
  localparam int D_XY   = T_GAM - 1;
  localparam int D_IV   = T_GAM - (2 + W);

  localparam logic signed [RW-1:0] SAT_HI = RW'({1'b0, {(W-1){1'b1}}});
  localparam logic signed [RW-1:0] SAT_LO = -SAT_HI - RW'(1);
  localparam logic signed [PW-1:0] HALF_V = PW'(1) <<< (VEL_FRAC - 1);
  localparam logic signed [PRW-1:0] HALF_G = PRW'(1) <<< (GAMMA_FRAC - 1);
  localparam logic [DSQ_W-1:0] ONE_DSQ = DSQ_W'(1) << (DSQ_W - 1);

  // pipeline control: one enable for every stage
  logic [LAT-1:0] vld;
  logic           en;

  assign en        = !vld[LAT-1] || res.ready;
  assign vec.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], vec.valid};
    end
  end

  // stage 1: velocity square, boost products, component squares
  logic signed [VEL_W-1:0] vel_c;
  logic signed [PW-1:0]    vel_e;
  logic signed [PW-1:0]    t_e;
  logic signed [PW-1:0]    z_e;
  logic signed [SQW-1:0]   t_s;
  logic signed [SQW-1:0]   x_s;
  logic signed [SQW-1:0]   y_s;
  logic signed [SQW-1:0]   z_s;

  // minus one light speed is pulled in to keep gamma finite
  assign vel_c = (vec.velocity == VEL_MIN) ? VEL_CLAMP : vec.velocity;
  assign vel_e = {{(PW-VEL_W){vel_c[VEL_W-1]}}, vel_c};
  assign t_e   = {{(PW-W){vec.time_in[W-1]}}, vec.time_in};
  assign z_e   = {{(PW-W){vec.zpos_in[W-1]}}, vec.zpos_in};
  assign t_s   = {{W{vec.time_in[W-1]}}, vec.time_in};
  assign x_s   = {{W{vec.xpos_in[W-1]}}, vec.xpos_in};
  assign y_s   = {{W{vec.ypos_in[W-1]}}, vec.ypos_in};
  assign z_s   = {{W{vec.zpos_in[W-1]}}, vec.zpos_in};

  logic signed [2*VEL_W-1:0] vsq1;
  logic signed [PW-1:0]      pz1;
  logic signed [PW-1:0]      pt1;
  logic        [SQW-1:0]     sqt1;
  logic        [SQW-1:0]     sqx1;
  logic        [SQW-1:0]     sqy1;
  logic        [SQW-1:0]     sqz1;
  logic        [2*W-1:0]     xy1;

  always_ff @(posedge clk) begin
    if (en) begin
      vsq1 <= vel_c * vel_c;
      pz1  <= (z_e <<< VEL_FRAC) - vel_e * t_e + HALF_V;
      pt1  <= (t_e <<< VEL_FRAC) - vel_e * z_e + HALF_V;
      sqt1 <= SQW'(t_s * t_s);
      sqx1 <= SQW'(x_s * x_s);
      sqy1 <= SQW'(y_s * y_s);
      sqz1 <= SQW'(z_s * z_s);
      xy1  <= {vec.xpos_in, vec.ypos_in};
    end
  end

  // stage 2: 1 - v^2, interval magnitude, rounded differences
  logic [SQW-1:0]   sqs;
  logic [DSQ_W-1:0] dsq2;
  logic [SQW-1:0]   mag2;
  logic [2*DW-1:0]  diff2;

  assign sqs = sqx1 + sqy1 + sqz1;

  always_ff @(posedge clk) begin
    if (en) begin
      dsq2  <= ONE_DSQ - vsq1[DSQ_W-1:0];
      mag2  <= (sqt1 >= sqs) ? (sqt1 - sqs) : (sqs - sqt1);
      // floor shift by the velocity fraction
      diff2 <= {pz1[PW-1:VEL_FRAC], pt1[PW-1:VEL_FRAC]};
    end
  end

  // gamma path: root of (1 - v^2) * 2^32, then 2^53 / root
  logic [ROOT_W-1:0]  groot;
  logic [GAMMA_W-1:0] gamma;

  lbzi_sqrt_pipe #(.IN_W(RAD_W)) u_gamma_root (
    .clk      (clk),
    .en       (en),
    .radicand ({1'b0, dsq2, {(RAD_W-DSQ_W-1){1'b0}}}),
    .root     (groot)
  );

  lbzi_div_pipe u_gamma_div (
    .clk     (clk),
    .en      (en),
    .divisor (groot),
    .gamma   (gamma)
  );

  // interval root, runs beside the gamma path
  logic [W-1:0] iv_root;
  logic [W-1:0] iv_d;

  lbzi_sqrt_pipe #(.IN_W(SQW)) u_interval_root (
    .clk      (clk),
    .en       (en),
    .radicand (mag2),
    .root     (iv_root)
  );

  lbzi_delay #(.WIDTH(W), .DEPTH(D_IV)) u_iv_delay (
    .clk  (clk),
    .en   (en),
    .din  (iv_root),
    .dout (iv_d)
  );

  // side payload delay lines
  logic [2*DW-1:0] diff_d;
  logic [2*W-1:0]  xy_d;

  lbzi_delay #(.WIDTH(2*DW), .DEPTH(D_DIFF)) u_diff_delay (
    .clk  (clk),
    .en   (en),
    .din  (diff2),
    .dout (diff_d)
  );

  lbzi_delay #(.WIDTH(2*W), .DEPTH(D_XY)) u_xy_delay (
    .clk  (clk),
    .en   (en),
    .din  (xy1),
    .dout (xy_d)
  );

  // product stage: gamma times each difference
  logic signed [PRW-1:0] g_e;
  logic signed [PRW-1:0] dz_e;
  logic signed [PRW-1:0] dt_e;
  logic signed [PRW-1:0] prod_z;
  logic signed [PRW-1:0] prod_t;
  logic        [W-1:0]   ivp;
  logic        [2*W-1:0] xyp;

  assign g_e  = {{(PRW-GAMMA_W){1'b0}}, gamma};
  assign dz_e = {{(PRW-DW){diff_d[2*DW-1]}}, diff_d[2*DW-1:DW]};
  assign dt_e = {{(PRW-DW){diff_d[DW-1]}}, diff_d[DW-1:0]};

  always_ff @(posedge clk) begin
    if (en) begin
      prod_z <= g_e * dz_e;
      prod_t <= g_e * dt_e;
      ivp    <= iv_d;
      xyp    <= xy_d;
    end
  end

  // output stage: round half up, saturate to the component range
  logic signed [PRW-1:0] rz_full;
  logic signed [PRW-1:0] rt_full;
  logic signed [RW-1:0]  rz;
  logic signed [RW-1:0]  rt;
  logic                  hz;
  logic                  lz;
  logic                  ht;
  logic                  lt;

  assign rz_full = prod_z + HALF_G;
  assign rt_full = prod_t + HALF_G;
  assign rz      = rz_full[PRW-1:GAMMA_FRAC];
  assign rt      = rt_full[PRW-1:GAMMA_FRAC];
  assign hz      = (rz > SAT_HI);
  assign lz      = (rz < SAT_LO);
  assign ht      = (rt > SAT_HI);
  assign lt      = (rt < SAT_LO);

  always_ff @(posedge clk) begin
    if (en) begin
      res.zpos_out  <= hz ? SAT_HI[W-1:0] : (lz ? SAT_LO[W-1:0] : rz[W-1:0]);
      res.time_out  <= ht ? SAT_HI[W-1:0] : (lt ? SAT_LO[W-1:0] : rt[W-1:0]);
      res.xpos_out  <= xyp[2*W-1:W];
      res.ypos_out  <= xyp[W-1:0];
      // a W-bit root of a 2W-bit magnitude always fits, so no interval clip
      res.interval  <= ivp;
      res.saturated <= hz || lz || ht || lt;
    end
  end

  assign res.valid = vld[LAT-1];

endmodule

// ----- rtl/lbzi_delay.sv -----
// enabled delay line for payload that rides alongside the pipeline
// no dependencies
`timescale 1ns / 1ps

module lbzi_delay #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WIDTH-1:0] din,
  output logic [WIDTH-1:0] dout
);

  logic [WIDTH-1:0] tap [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      tap[0] <= din;
      for (int i = 1; i < DEPTH; i++) begin
        tap[i] <= tap[i-1];
      end
    end
  end

  assign dout = tap[DEPTH-1];

endmodule

// ----- rtl/lbzi_sqrt_pipe.sv -----
// pipelined restoring integer square root, one root bit per stage
// no dependencies
`timescale 1ns / 1ps

module lbzi_sqrt_pipe #(
  parameter int IN_W = 64
) (
  input  logic              clk,
  input  logic              en,
  input  logic [IN_W-1:0]   radicand,
  output logic [IN_W/2-1:0] root
);

  localparam int OUT_W = IN_W / 2;
  localparam int REM_W = OUT_W + 2;

  logic [REM_W-1:0] rem_q  [OUT_W];
  logic [OUT_W-1:0] root_q [OUT_W];
  logic [IN_W-1:0]  rad_q  [OUT_W];

  for (genvar k = 0; k < OUT_W; k++) begin : g_stage
    logic [REM_W-1:0] rem_i;
    logic [OUT_W-1:0] root_i;
    logic [IN_W-1:0]  rad_i;
    logic [REM_W-1:0] cur;
    logic [REM_W-1:0] trial;
    logic             ge;

    if (k == 0) begin : g_first
      assign rem_i  = '0;
      assign root_i = '0;
      assign rad_i  = radicand;
    end else begin : g_rest
      assign rem_i  = rem_q[k-1];
      assign root_i = root_q[k-1];
      assign rad_i  = rad_q[k-1];
    end

    // bring down the next two radicand bits and try root*4+1
    assign cur   = {rem_i[OUT_W-1:0], rad_i[IN_W-1 -: 2]};
    assign trial = {root_i, 2'b01};
    assign ge    = (cur >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k]  <= ge ? (cur - trial) : cur;
        root_q[k] <= {root_i[OUT_W-2:0], ge};
        rad_q[k]  <= {rad_i[IN_W-3:0], 2'b00};
      end
    end
  end

  assign root = root_q[OUT_W-1];

endmodule

// ----- rtl/lbzi_div_pipe.sv -----
// pipelined restoring divider forming gamma = 2^53 / root, one bit per stage
// depends on lbzi_pkg
`timescale 1ns / 1ps

module lbzi_div_pipe (
  input  logic                          clk,
  input  logic                          en,
  input  logic [lbzi_pkg::ROOT_W-1:0]   divisor,
  output logic [lbzi_pkg::GAMMA_W-1:0]  gamma
);
  import lbzi_pkg::*;

  localparam int R_W = ROOT_W + 1;
  // dividend bits above the quotient field; below it the dividend is all zero
  localparam logic [R_W-1:0] R_INIT = R_W'(64'd1 << (GAMMA_EXP - GAMMA_W));

  logic [R_W-1:0]     rem_q [GAMMA_W];
  logic [GAMMA_W-1:0] quo_q [GAMMA_W];
  logic [ROOT_W-1:0]  dvs_q [GAMMA_W];

  for (genvar k = 0; k < GAMMA_W; k++) begin : g_stage
    logic [R_W-1:0]     rem_i;
    logic [GAMMA_W-1:0] quo_i;
    logic [ROOT_W-1:0]  dvs_i;
    logic [R_W-1:0]     cur;
    logic               ge;

    if (k == 0) begin : g_first
      assign rem_i = R_INIT;
      assign quo_i = '0;
      assign dvs_i = divisor;
    end else begin : g_rest
      assign rem_i = rem_q[k-1];
      assign quo_i = quo_q[k-1];
      assign dvs_i = dvs_q[k-1];
    end

    assign cur = {rem_i[R_W-2:0], 1'b0};
    assign ge  = (cur >= {1'b0, dvs_i});

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k] <= ge ? (cur - {1'b0, dvs_i}) : cur;
        quo_q[k] <= {quo_i[GAMMA_W-2:0], ge};
        dvs_q[k] <= dvs_i;
      end
    end
  end

  assign gamma = quo_q[GAMMA_W-1];

endmodule

// ----- rtl/lbzi_checker.sv -----
// port-level checks for the boost pipeline, bound to the top level
// depends on lorentz_boost_z_and_interval and lbzi_pkg
`timescale 1ns / 1ps

module lbzi_checker #(
  parameter int COMP_WIDTH = lbzi_pkg::COMP_WIDTH_DEF
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [COMP_WIDTH-1:0] time_out,
  input logic [COMP_WIDTH-1:0] zpos_out,
  input logic                  saturated
);

  localparam logic [COMP_WIDTH-1:0] HI = {1'b0, {(COMP_WIDTH-1){1'b1}}};
  localparam logic [COMP_WIDTH-1:0] LO = {1'b1, {(COMP_WIDTH-1){1'b0}}};

  // input side only stalls when an output transaction is held
  a_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow output backpressure");

  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("held result dropped");

  // saturation implies a boosted component sits at a bound
  a_sat_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |->
      (time_out == HI || time_out == LO || zpos_out == HI || zpos_out == LO))
    else $error("saturated flag without clipped component");

endmodule

bind lorentz_boost_z_and_interval lbzi_checker #(.COMP_WIDTH(COMP_WIDTH)) u_lbzi_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (vec.ready),
  .out_valid (res.valid),
  .out_ready (res.ready),
  .time_out  (res.time_out),
  .zpos_out  (res.zpos_out),
  .saturated (res.saturated)
);
